### rtl/rgbp_pkg.sv
// ============================================================================
// rgbp_pkg
// Shared types and constants of the RGB to gray two-bitplane packer.
// ============================================================================
package rgbp_pkg;

    // Pixel and register widths.
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 10;
    localparam int PROD_W     = PIX_W + CFG_W;     // one weighted component
    localparam int SUM_W      = PROD_W + 2;        // sum of three components
    localparam int GRAY_W     = 10;                // quotient never exceeds 782
    localparam int POS_W      = 3;                 // bit position in a byte
    localparam int BYTE_W     = 8;

    // APB side.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Division by 1000 as a multiply by a rounded-up reciprocal. With a
    // 20-bit dividend and a shift of 20 + 10 bits the quotient is exact.
    localparam int                 GRAY_DIV   = 1000;
    localparam int                 GRAY_SHIFT = SUM_W + 10;
    localparam int                 RECIP_W    = 21;
    localparam int                 QPROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] GRAY_RECIP =
        RECIP_W'(((1 << GRAY_SHIFT) + GRAY_DIV - 1) / GRAY_DIV);

    // Bit packing: the first pixel of a group lands in the top bit.
    localparam logic [BYTE_W-1:0] BIT_SEED     = 8'h01;
    localparam logic [POS_W-1:0]  LAST_BIT_POS = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_THRESHOLD_LOW  = 10'd85;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_HIGH = 10'd170;
    localparam logic [CFG_W-1:0] RST_WEIGHT_RED     = 10'd212;
    localparam logic [CFG_W-1:0] RST_WEIGHT_GREEN   = 10'd715;
    localparam logic [CFG_W-1:0] RST_WEIGHT_BLUE    = 10'd72;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_THRESHOLD_LOW  = 3'd0,
        REG_THRESHOLD_HIGH = 3'd1,
        REG_WEIGHT_RED     = 3'd2,
        REG_WEIGHT_GREEN   = 3'd3,
        REG_WEIGHT_BLUE    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] threshold_low;
        logic [CFG_W-1:0] threshold_high;
        logic [CFG_W-1:0] weight_red;
        logic [CFG_W-1:0] weight_green;
        logic [CFG_W-1:0] weight_blue;
    } cfg_t;

    // One classified pixel as it waits between the front and the packer.
    typedef struct packed {
        logic black_bit;
        logic gray_bit;
        logic last;
    } pix_class_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### rtl/rgb_to_gray_bitplane_packer_core.sv
// ============================================================================
// rgb_to_gray_bitplane_packer_core
// RGB pixel stream in, packed black-plane and gray-plane byte pairs out.
// ============================================================================
// With s_tready high the block turns one RGB pixel per clock into two plane bits.
// Gray is the truncated quotient of (weight_red*red + weight_green*green +
// weight_blue*blue) by 1000, kept at full width. The black bit is set when
// gray is above threshold_high; the gray bit is set when gray lies strictly
// between threshold_low and threshold_high. Eight pixels fill one byte pair,
// the first pixel in bit 7; a pixel transferred with s_tlast closes the pair
// early, the unused low bits are zero and m_tlast marks the pair. While the
// master side takes every pair, the sustained rate is one pixel per clock. A
// pixel passes the four register stages of the front (products, sum, reciprocal
// multiply, threshold compare), enters a queue of QUEUE_DEPTH entries and is
// packed by a single packer that can take one queued pixel per clock while its
// output register has room, and the finished pair is registered there to
// drive m_tvalid. When the master side stalls, the output register holds the
// finished pair while the packer keeps filling the next one; the queue absorbs
// the rest, and s_tready drops only once the queue is full and a classified
// pixel waits at the end of the front.
// Registers must be written over APB only while the block is idle; the block
// does not enforce this. Byte addresses: 0 threshold_low, 4 threshold_high,
// 8 weight_red, 12 weight_green and 16 weight_blue, 10 bits each; paddr[1:0]
// is ignored and writes to the remaining word addresses are dropped.
// ============================================================================
module rgb_to_gray_bitplane_packer_core
    import rgbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // APB configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // Pixel input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*PIX_W-1:0]    s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic                  s_tlast,   // last_pixel

    // Byte pair output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*BYTE_W-1:0]   m_tdata,   // black_byte [7:0], gray_byte [15:8]
    output logic                  m_tlast    // frame_end
);

    cfg_t       cfg;
    fifo_stat_t q_stat;
    logic       push, pop;
    pix_class_t push_data, pop_data;

    // Configuration registers feed the front directly; the user must change them
    // only while no pixel is in flight, which the block does not enforce.
    rgbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front accepts pixels and reduces each one to its two plane bits
    // plus the frame marker.
    rgbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // The queue decouples the front's pipeline from the output stalls.
    rgbp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // The packer owns the bit position and both accumulators, and drives
    // the master side from its output register.
    rgbp_pack u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .entry    (pop_data),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/rgbp_regs.sv
// ============================================================================
// rgbp_regs
// APB register file holding the thresholds and the color weights.
// ============================================================================
module rgbp_regs
    import rgbp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic [CFG_W-1:0] wr_val;
    logic [CFG_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_val  = pwdata[CFG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_low  <= RST_THRESHOLD_LOW;
            cfg_reg.threshold_high <= RST_THRESHOLD_HIGH;
            cfg_reg.weight_red     <= RST_WEIGHT_RED;
            cfg_reg.weight_green   <= RST_WEIGHT_GREEN;
            cfg_reg.weight_blue    <= RST_WEIGHT_BLUE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD_LOW:  cfg_reg.threshold_low  <= wr_val;
                REG_THRESHOLD_HIGH: cfg_reg.threshold_high <= wr_val;
                REG_WEIGHT_RED:     cfg_reg.weight_red     <= wr_val;
                REG_WEIGHT_GREEN:   cfg_reg.weight_green   <= wr_val;
                REG_WEIGHT_BLUE:    cfg_reg.weight_blue    <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD_LOW:  rd_val = cfg_reg.threshold_low;
            REG_THRESHOLD_HIGH: rd_val = cfg_reg.threshold_high;
            REG_WEIGHT_RED:     rd_val = cfg_reg.weight_red;
            REG_WEIGHT_GREEN:   rd_val = cfg_reg.weight_green;
            REG_WEIGHT_BLUE:    rd_val = cfg_reg.weight_blue;
            default:            rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_val);
    assign cfg    = cfg_reg;

endmodule

### rtl/rgbp_front.sv
// ============================================================================
// rgbp_front
// Four-stage pipeline: weighted products, sum, divide by 1000, classify.
// ============================================================================
module rgbp_front
    import rgbp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*PIX_W-1:0]    s_tdata,
    input  logic                  s_tlast,
    input  fifo_stat_t            q_stat,
    output logic                  push,
    output pix_class_t            push_data
);

    logic              adv;
    logic [PIX_W-1:0]  red, green, blue;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              last1_reg, last2_reg, last3_reg;
    logic [PROD_W-1:0] prod_red_reg, prod_green_reg, prod_blue_reg;
    logic [PROD_W-1:0] prod_red_next, prod_green_next, prod_blue_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [QPROD_W-1:0] quot_prod;
    logic [GRAY_W-1:0] gray_reg, gray_next;
    pix_class_t        class_reg, class_next;

    // The whole pipeline moves as one; it halts only when a classified
    // pixel sits at the end and the queue has no room for it.
    assign adv      = !(v4_reg && q_stat.full);
    assign s_tready = adv;
    assign push     = v4_reg && adv;
    assign push_data = class_reg;

    assign red   = s_tdata[PIX_W-1:0];
    assign green = s_tdata[2*PIX_W-1:PIX_W];
    assign blue  = s_tdata[3*PIX_W-1:2*PIX_W];

    always_comb begin
        prod_red_next   = PROD_W'(cfg.weight_red)   * PROD_W'(red);
        prod_green_next = PROD_W'(cfg.weight_green) * PROD_W'(green);
        prod_blue_next  = PROD_W'(cfg.weight_blue)  * PROD_W'(blue);
        sum_next  = SUM_W'(prod_red_reg) + SUM_W'(prod_green_reg) + SUM_W'(prod_blue_reg);
        quot_prod = QPROD_W'(sum_reg) * QPROD_W'(GRAY_RECIP);
        gray_next = quot_prod[GRAY_SHIFT +: GRAY_W];
        class_next.black_bit = gray_reg > cfg.threshold_high;
        class_next.gray_bit  = (gray_reg > cfg.threshold_low) &&
                               (gray_reg < cfg.threshold_high);
        class_next.last      = last3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_red_reg   <= prod_red_next;
            prod_green_reg <= prod_green_next;
            prod_blue_reg  <= prod_blue_next;
            last1_reg      <= s_tlast;
            sum_reg        <= sum_next;
            last2_reg      <= last1_reg;
            gray_reg       <= gray_next;
            last3_reg      <= last2_reg;
            class_reg      <= class_next;
        end
    end

endmodule

### rtl/rgbp_fifo.sv
// ============================================================================
// rgbp_fifo
// Short queue of classified pixels between the front and the packer.
// ============================================================================
module rgbp_fifo
    import rgbp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pix_class_t push_data,
    input  logic       pop,
    output pix_class_t pop_data,
    output fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    pix_class_t     mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data   = mem[rd_ptr_reg];
    assign stat.full  = count_reg == FULL_CNT;
    assign stat.empty = count_reg == '0;

endmodule

### rtl/rgbp_pack.sv
// ============================================================================
// rgbp_pack
// Collects plane bits into byte pairs and holds them in the output register.
// ============================================================================
module rgbp_pack
    import rgbp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pix_class_t            entry,
    input  fifo_stat_t            q_stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*BYTE_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    logic [POS_W-1:0]  bit_pos_reg;
    logic [BYTE_W-1:0] black_acc_reg, gray_acc_reg;
    logic [BYTE_W-1:0] black_next, gray_next, mask;
    logic              m_valid_reg, m_last_reg;
    logic [BYTE_W-1:0] m_black_reg, m_gray_reg;
    logic              emit, slot_free;

    always_comb begin
        mask       = BIT_SEED << (LAST_BIT_POS - bit_pos_reg);
        black_next = black_acc_reg | (entry.black_bit ? mask : '0);
        gray_next  = gray_acc_reg  | (entry.gray_bit  ? mask : '0);
        emit       = (bit_pos_reg == LAST_BIT_POS) || entry.last;
        slot_free  = !m_valid_reg || m_tready;
        // A pixel that closes a byte waits for room in the output register.
        pop        = !q_stat.empty && (!emit || slot_free);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg   <= '0;
            black_acc_reg <= '0;
            gray_acc_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                if (emit) begin
                    bit_pos_reg   <= '0;
                    black_acc_reg <= '0;
                    gray_acc_reg  <= '0;
                end else begin
                    bit_pos_reg   <= bit_pos_reg + 1'b1;
                    black_acc_reg <= black_next;
                    gray_acc_reg  <= gray_next;
                end
            end
            if (pop && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            m_black_reg <= black_next;
            m_gray_reg  <= gray_next;
            m_last_reg  <= entry.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_gray_reg, m_black_reg};
    assign m_tlast  = m_last_reg;

endmodule

### rtl/rgbp_checker.sv
// ============================================================================
// rgbp_checker
// Port-level assertions for the packer core, bound to the top level.
// ============================================================================
module rgbp_checker
    import rgbp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  psel,
    input logic                  pready,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [2*BYTE_W-1:0]   m_tdata,
    input logic                  m_tlast
);

    // A stalled byte pair must stay on the bus unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output pair changed while stalled");

    // A pixel cannot be both above and below threshold_high.
    a_planes_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[BYTE_W-1:0] & m_tdata[2*BYTE_W-1:BYTE_W]) == '0)
        else $error("black and gray planes overlap");

    // Coming out of reset the pipeline is empty and takes pixels.
    a_ready_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> s_tready && !m_tvalid)
        else $error("not ready after reset");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("pready low during an access");

endmodule

bind rgb_to_gray_bitplane_packer_core rgbp_checker u_checker (.*);

### tb/sv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the RGB to gray two-bitplane packer.
// ============================================================================
// Pixels are sent through the slave stream and byte pairs are collected from
// the master stream. A shadow packer inside the bench classifies every
// accepted pixel with the current register values and queues the byte pair
// it expects. Each byte pair is compared in order against that queue.
// Registers are programmed over APB between phases, while the block is idle.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbp_pkg::*;

    // Run control.
    localparam int CYCLE_LIMIT        = 300000;
    localparam int DRAIN_CYCLES       = 24;     // front, queue and packer with margin
    localparam int RANDOM_PHASE_ITEMS = 171;
    localparam int LAST_PIXEL_PCT     = 10;

    // Register indexes that decode to nothing; writes there must be dropped.
    localparam logic [2:0] FIRST_UNUSED_INDEX = 3'd5;
    localparam int         UNUSED_INDEXES     = 3;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } pixel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] black;
        logic [BYTE_W-1:0] gray;
        logic              frame_end;
    } byte_pair_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [3*PIX_W-1:0]    s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
    logic                  s_tlast = 1'b0; // last_pixel

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*BYTE_W-1:0]   m_tdata;        // black_byte [7:0], gray_byte [15:8]
    logic                  m_tlast;        // frame_end

    rgb_to_gray_bitplane_packer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock period.
    always #2 aclk = ~aclk;

    // Shadow copy of the registers and of the packer state.
    cfg_t              plane_cfg = '{
        threshold_low:  RST_THRESHOLD_LOW,
        threshold_high: RST_THRESHOLD_HIGH,
        weight_red:     RST_WEIGHT_RED,
        weight_green:   RST_WEIGHT_GREEN,
        weight_blue:    RST_WEIGHT_BLUE
    };
    logic [POS_W-1:0]  pack_pos = '0;
    logic [BYTE_W-1:0] black_acc = '0;
    logic [BYTE_W-1:0] gray_acc = '0;

    pixel_t     pending_pixels[$];   // pixels waiting to be offered
    byte_pair_t expected_pairs[$];   // byte pairs the block still owes us

    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          mismatches = 0;
    int          pixels_in = 0;
    int          pairs_out = 0;
    int          settings_used = 0;
    int unsigned cycles = 0;
    bit          pix_taken = 1'b0;

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // Classify one pixel with the current register values and pack its two
    // bits. A byte pair is owed once eight bits are in or the frame ends; the
    // unfilled low bits of a short pair stay zero.
    function automatic void pack_pixel(pixel_t p);
        int unsigned       weighted;
        int unsigned       gray;
        logic [BYTE_W-1:0] mask;
        weighted = plane_cfg.weight_red * p.red + plane_cfg.weight_green * p.green
                 + plane_cfg.weight_blue * p.blue;
        gray = weighted / GRAY_DIV;
        mask = BIT_SEED << (LAST_BIT_POS - pack_pos);
        if (gray > plane_cfg.threshold_high) begin
            black_acc |= mask;
        end
        if (gray > plane_cfg.threshold_low && gray < plane_cfg.threshold_high) begin
            gray_acc |= mask;
        end
        if (pack_pos == LAST_BIT_POS || p.last) begin
            expected_pairs.push_back(byte_pair_t'{black_acc, gray_acc, p.last});
            pack_pos = '0;
            black_acc = '0;
            gray_acc = '0;
        end else begin
            pack_pos++;
        end
    endfunction

    // Monitor: both streams are sampled on the rising edge. Every accepted
    // pixel goes through the shadow packer, and every byte pair transfer is
    // compared with the oldest pair still owed.
    always @(posedge aclk) begin : monitor
        byte_pair_t want;
        pix_taken = aresetn && s_tvalid && s_tready;
        if (pix_taken) begin
            pack_pixel(pixel_t'{s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast});
            pixels_in++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            pairs_out++;
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("byte pair black=%h gray=%h last=%b not owed",
                                          m_tdata[7:0], m_tdata[15:8], m_tlast));
            end else begin
                want = expected_pairs.pop_front();
                if (m_tdata[7:0] !== want.black || m_tdata[15:8] !== want.gray ||
                    m_tlast !== want.frame_end) begin
                    report_mismatch($sformatf(
                        "byte pair got black=%h gray=%h last=%b, want %h %h %b",
                        m_tdata[7:0], m_tdata[15:8], m_tlast,
                        want.black, want.gray, want.frame_end));
                end
            end
        end
    end

    // Driver: on the falling edge a pixel that was not taken is held as it
    // is; otherwise the next one is offered, or the stream idles at random.
    always @(negedge aclk) begin : driver
        pixel_t pix;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || pix_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                pix = pending_pixels.pop_front();
                s_tdata  <= {pix.blue, pix.green, pix.red};
                s_tlast  <= pix.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog against a hung stream.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles, %0d pixels queued, %0d pairs owed",
                     cycles, pending_pixels.size(), expected_pairs.size());
            $display("Verification failed");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle; the register takes the
    // value on the edge that closes the access cycle. Bits above the register
    // width are filled with noise, since the block has to drop them.
    task automatic apb_write(logic [2:0] index, logic [CFG_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {(APB_DATA_W - CFG_W)'($urandom()), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_THRESHOLD_LOW:  plane_cfg.threshold_low  = value;
            REG_THRESHOLD_HIGH: plane_cfg.threshold_high = value;
            REG_WEIGHT_RED:     plane_cfg.weight_red     = value;
            REG_WEIGHT_GREEN:   plane_cfg.weight_green   = value;
            REG_WEIGHT_BLUE:    plane_cfg.weight_blue    = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(reg_index_t index, logic [CFG_W-1:0] stored);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(stored)) begin
            report_mismatch($sformatf("register %s reads %h, holds %h",
                                      index.name(), prdata, stored));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        apb_read_check(REG_THRESHOLD_LOW,  plane_cfg.threshold_low);
        apb_read_check(REG_THRESHOLD_HIGH, plane_cfg.threshold_high);
        apb_read_check(REG_WEIGHT_RED,     plane_cfg.weight_red);
        apb_read_check(REG_WEIGHT_GREEN,   plane_cfg.weight_green);
        apb_read_check(REG_WEIGHT_BLUE,    plane_cfg.weight_blue);
    endtask

    task automatic program_planes(cfg_t c);
        apb_write(REG_THRESHOLD_LOW,  c.threshold_low);
        apb_write(REG_THRESHOLD_HIGH, c.threshold_high);
        apb_write(REG_WEIGHT_RED,     c.weight_red);
        apb_write(REG_WEIGHT_GREEN,   c.weight_green);
        apb_write(REG_WEIGHT_BLUE,    c.weight_blue);
        check_registers();
        settings_used++;
    endtask

    // Idle means nothing left to offer, nothing on the wire and nothing owed.
    // A pixel that closes no pair may still sit in the pipeline, so the
    // drain time is added before the registers may change.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_pixels.size() != 0 || s_tvalid || expected_pairs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic add_pixel(int red, int green, int blue, bit last);
        pending_pixels.push_back(pixel_t'{PIX_W'(red), PIX_W'(green), PIX_W'(blue), last});
    endtask

    // Component level biased toward the two ends of the range.
    function automatic int pick_level();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 255 : 0;
        end
        return $urandom_range(0, 255);
    endfunction

    task automatic run_random_phase(cfg_t c, int src_pct, int sink_pct);
        program_planes(c);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int k = 0; k < RANDOM_PHASE_ITEMS; k++) begin
            add_pixel(pick_level(), pick_level(), pick_level(),
                      $urandom_range(0, 99) < LAST_PIXEL_PCT);
        end
        wait_idle();
    endtask

    initial begin : stimulus
        cfg_t c;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Phase one: the reset values. With equal component levels gray comes
        // out one below the level, so 86/87 and 171/172 straddle the default
        // thresholds. A frame closes after seven pixels (a short pair), after
        // exactly eight (full pair and frame end together) and after one.
        src_idle_pct  = 37;
        sink_idle_pct = 80;
        check_registers();
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(255, 0, 0, 0);
        add_pixel(0, 255, 0, 0);
        add_pixel(0, 0, 255, 0);
        add_pixel(128, 128, 128, 0);
        add_pixel(60, 60, 60, 1);
        add_pixel(86, 86, 86, 0);
        add_pixel(87, 87, 87, 0);
        add_pixel(171, 171, 171, 0);
        add_pixel(172, 172, 172, 0);
        add_pixel(170, 170, 170, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(0, 0, 0, 0);
        add_pixel(100, 100, 100, 1);
        add_pixel(200, 10, 30, 1);
        wait_idle();

        // Phase two: gray equals red exactly, so the threshold edges are hit
        // on the value. Writes to the undecoded addresses must change nothing,
        // which the readback that follows them confirms.
        c = '{threshold_low: 10'd85, threshold_high: 10'd170,
              weight_red: 10'd1000, weight_green: 10'd0, weight_blue: 10'd0};
        program_planes(c);
        for (int k = 0; k < UNUSED_INDEXES; k++) begin
            apb_write(FIRST_UNUSED_INDEX + 3'(k), CFG_W'($urandom()));
        end
        check_registers();
        add_pixel(84, pick_level(), pick_level(), 0);
        add_pixel(85, pick_level(), pick_level(), 0);
        add_pixel(86, pick_level(), pick_level(), 0);
        add_pixel(169, pick_level(), pick_level(), 0);
        add_pixel(170, pick_level(), pick_level(), 0);
        add_pixel(171, pick_level(), pick_level(), 0);
        add_pixel(255, pick_level(), pick_level(), 0);
        add_pixel(0, pick_level(), pick_level(), 0);
        add_pixel(255, 255, 255, 1);
        wait_idle();

        // Random phases. The default setting is written back explicitly,
        // then every register goes to zero.
        c = '{threshold_low: RST_THRESHOLD_LOW, threshold_high: RST_THRESHOLD_HIGH,
              weight_red: RST_WEIGHT_RED, weight_green: RST_WEIGHT_GREEN,
              weight_blue: RST_WEIGHT_BLUE};
        run_random_phase(c, 37, 80);
        c = '{default: '0};
        run_random_phase(c, 37, 80);

        // Now the receiver is the faster side. Full-scale weights reach the
        // top gray level of 782; thresholds at the two ends leave every
        // nonzero gray in the gray plane. Then equal thresholds, which can
        // never set a gray bit.
        c = '{threshold_low: '0, threshold_high: '1,
              weight_red: '1, weight_green: '1, weight_blue: '1};
        run_random_phase(c, 80, 37);
        c = '{threshold_low: 10'd300, threshold_high: 10'd300,
              weight_red: CFG_W'($urandom()), weight_green: CFG_W'($urandom()),
              weight_blue: CFG_W'($urandom())};
        run_random_phase(c, 80, 37);

        // Full rate on both sides: low threshold above the high one, then a
        // fully random setting.
        c = '{threshold_low: 10'd600, threshold_high: 10'd200,
              weight_red: CFG_W'($urandom()), weight_green: CFG_W'($urandom()),
              weight_blue: CFG_W'($urandom())};
        run_random_phase(c, 0, 0);
        c = '{threshold_low: CFG_W'($urandom_range(0, 800)),
              threshold_high: CFG_W'($urandom_range(0, 800)),
              weight_red: CFG_W'($urandom()), weight_green: CFG_W'($urandom()),
              weight_blue: CFG_W'($urandom())};
        run_random_phase(c, 0, 0);

        $display("Sent %0d pixel transfers and checked %0d byte pair transfers",
                 pixels_in, pairs_out);
        $display("over %0d register settings in %0d cycles; %0d mismatches",
                 settings_used, cycles, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rgbp_pkg.sv
rtl/rgbp_regs.sv
rtl/rgbp_front.sv
rtl/rgbp_fifo.sv
rtl/rgbp_pack.sv
rtl/rgb_to_gray_bitplane_packer_core.sv
rtl/rgbp_checker.sv
tb/sv/testbench.sv
